// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// ----- hdl/pmst_pkg.sv -----
// ----------------------------------------------------------------------------
// pmst_pkg
// Shared constants and types of the spanning tree block.
// ----------------------------------------------------------------------------
package pmst_pkg;
   localparam int MaxVert = 64;
   localparam int VW = $clog2(MaxVert);
   localparam int AW = 2 * VW;
   localparam int KW = 31;
   localparam int CW = 7;
   // Width of the per-entry epoch mark in the edge store.
   localparam int EW = 4;

   localparam logic OP_EDGE  = 1'b0;
   localparam logic OP_SOLVE = 1'b1;

   localparam logic [2:0] ST_TREE_EDGE = 3'd0;
   localparam logic [2:0] ST_EMPTY     = 3'd1;
   localparam logic [2:0] ST_NO_TREE   = 3'd2;
   localparam logic [2:0] ST_BAD_VERT  = 3'd3;
   localparam logic [2:0] ST_BAD_LEN   = 3'd4;
   localparam logic [2:0] ST_TOO_MANY  = 3'd5;
   localparam logic [2:0] ST_FAILED    = 3'd6;

   // Request from the sequencer to the edge store.
   typedef struct packed {
      logic          wr;
      logic [AW-1:0] waddr;
      logic [KW-1:0] wdata;
      logic          clr;
      logic [AW-1:0] raddr;
   } mem_req_type;
endpackage

// ----- hdl/pmst_store.sv -----
// ----------------------------------------------------------------------------
// pmst_store
// Adjacency matrix: weight memory plus an epoch mark per entry.
// ----------------------------------------------------------------------------
module pmst_store import pmst_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  mem_req_type   req,
   output logic          busy,
   output logic          rd_present,
   output logic [KW-1:0] rd_weight
);
   logic [EW+KW-1:0] mem [MaxVert*MaxVert];
   logic [EW-1:0]    epoch_ff;
   logic             sweep_ff;
   logic [AW-1:0]    sweep_addr_ff;
   logic [EW+KW-1:0] rd_ff;

   // An entry is present when its mark equals the current epoch, which runs
   // from 1 up to all ones. A sweep writes mark 0 everywhere after reset and
   // whenever the epoch wraps, so no stale mark can alias a later epoch.
   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff <= EW'(1); sweep_ff <= 1'b1; sweep_addr_ff <= '0;
      end else if (sweep_ff) begin
         sweep_addr_ff <= sweep_addr_ff + 1'b1;
         if (sweep_addr_ff == '1) sweep_ff <= 1'b0;
      end else if (req.clr) begin
         if (epoch_ff == '1) begin
            epoch_ff <= EW'(1); sweep_ff <= 1'b1;
         end else begin
            epoch_ff <= epoch_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sweep_ff) begin
         mem[sweep_addr_ff] <= '0;
      end else if (req.wr) begin
         mem[req.waddr] <= {epoch_ff, req.wdata};
      end
      rd_ff <= mem[req.raddr];
   end

   assign busy       = sweep_ff;
   assign rd_present = (rd_ff[EW+KW-1:KW] == epoch_ff);
   assign rd_weight  = rd_ff[KW-1:0];
endmodule

// ----- hdl/pmst_seq.sv -----
// ----------------------------------------------------------------------------
// pmst_seq
// Sequencer: edge checks and Prim relax and pick passes.
// ----------------------------------------------------------------------------
module pmst_seq import pmst_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write,
   input  logic [CW-1:0] csr_data,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_opcode,
   input  logic [7:0]    req_first_vertex,
   input  logic [7:0]    req_second_vertex,
   input  logic [32:0]   req_edge_length,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [2:0]    rsp_status,
   output logic [6:0]    rsp_child_vertex,
   output logic [6:0]    rsp_parent_vertex,
   output logic          rsp_last,
   output mem_req_type   mreq,
   input  logic          store_busy,
   input  logic          rd_present,
   input  logic [KW-1:0] rd_weight
);
   typedef enum logic [3:0] {
      S_IDLE, S_WR2, S_RELAX, S_RWAIT, S_PICK, S_PWAIT, S_EREAD, S_EMIT, S_ONE,
      S_DONE
   } state_type;

   state_type     state_ff;
   logic [CW-1:0] nv_ff;
   logic [11:0]   count_ff;
   logic          failed_ff;
   logic [VW-1:0] a_ff, b_ff;
   logic [KW-1:0] len_ff;
   logic [VW:0]   u_ff, j_ff, jd_ff, added_ff;
   logic [VW:0]   pick_ff;
   logic [KW-1:0] pkey_ff;
   logic [KW-1:0] key_ff [MaxVert];
   logic [VW-1:0] par_ff [MaxVert];
   logic [KW-1:0] kq_ff;
   logic [VW-1:0] pq_ff;
   logic [MaxVert-1:0] kv_ff, tree_ff;
   logic          rv_ff;
   logic [2:0]    rst_ff;
   logic [6:0]    rc_ff, rp_ff;
   logic          rl_ff;

   logic [VW:0]   n;
   logic [12:0]   n13;
   logic [12:0]   limit;
   logic          fire, dsel, cand;
   logic [2:0]    chk;
   logic [VW-1:0] jd, jw;

   assign n = (nv_ff > CW'(MaxVert)) ? (VW+1)'(MaxVert) : nv_ff[VW:0];
   assign n13 = 13'(n);
   assign limit = (n13 * (n13 - {12'd0, n != 0})) >> 1;
   assign fire = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || rv_ff || store_busy;
   assign jd = jd_ff[VW-1:0];
   assign jw = j_ff[VW-1:0];
   // One compare decides relax updates and a second one decides picks; the key
   // arrives registered in the cycle after its address.
   assign dsel = rd_weight < kq_ff;
   assign cand = !tree_ff[jd] && kv_ff[jd] && (pick_ff == n || kq_ff < pkey_ff);

   always_comb begin
      chk = ST_TREE_EDGE;
      priority if ({1'b0, count_ff} >= limit) chk = ST_TOO_MANY;
      else if (req_first_vertex == 8'd0 || req_first_vertex > {{(7-VW){1'b0}}, n}
         || req_second_vertex == 8'd0
         || req_second_vertex > {{(7-VW){1'b0}}, n}) chk = ST_BAD_VERT;
      else if (req_edge_length[32:31] != 2'b00) chk = ST_BAD_LEN;
      else chk = ST_TREE_EDGE;
   end

   always_comb begin
      mreq = '0;
      mreq.raddr = {u_ff[VW-1:0], jw};
      if (state_ff == S_IDLE && fire && req_opcode == OP_EDGE && !failed_ff
          && chk == ST_TREE_EDGE) begin
         mreq.wr = 1'b1;
         mreq.waddr = {VW'(req_first_vertex - 8'd1), VW'(req_second_vertex - 8'd1)};
         mreq.wdata = req_edge_length[KW-1:0];
      end else if (state_ff == S_WR2) begin
         mreq.wr = 1'b1;
         mreq.waddr = {b_ff, a_ff};
         mreq.wdata = len_ff;
      end
      mreq.clr = (state_ff == S_DONE);
   end

   always_ff @(posedge clock) begin
      kq_ff <= key_ff[jw];
      pq_ff <= par_ff[jw];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; nv_ff <= '0; count_ff <= '0; failed_ff <= 1'b0;
         rv_ff <= 1'b0; kv_ff <= '0; tree_ff <= '0;
      end else begin
         if (csr_write) nv_ff <= csr_data;
         if (rv_ff && !rsp_stall && state_ff != S_EMIT) rv_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (fire) begin
                  if (req_opcode == OP_EDGE) begin
                     if (!failed_ff) begin
                        if (chk != ST_TREE_EDGE) begin
                           failed_ff <= 1'b1; rv_ff <= 1'b1; rst_ff <= chk;
                           rc_ff <= '0; rp_ff <= '0; rl_ff <= 1'b1;
                        end else begin
                           a_ff <= VW'(req_first_vertex - 8'd1);
                           b_ff <= VW'(req_second_vertex - 8'd1);
                           len_ff <= req_edge_length[KW-1:0];
                           count_ff <= count_ff + 12'd1;
                           state_ff <= S_WR2;
                        end
                     end
                  end else begin
                     rc_ff <= '0; rp_ff <= '0; rl_ff <= 1'b1;
                     if (failed_ff) begin
                        rst_ff <= ST_FAILED; state_ff <= S_ONE;
                     end else if (n == 0) begin
                        rst_ff <= ST_NO_TREE; state_ff <= S_ONE;
                     end else if (n == 1) begin
                        rst_ff <= ST_EMPTY; state_ff <= S_ONE;
                     end else begin
                        kv_ff <= '0; tree_ff <= {{(MaxVert-1){1'b0}}, 1'b1};
                        u_ff <= '0; j_ff <= '0; added_ff <= (VW+1)'(1);
                        state_ff <= S_RELAX;
                     end
                  end
               end
            end
            S_WR2: state_ff <= S_IDLE;
            S_RELAX: begin
               // Read issued for j_ff; result lands next cycle as jd_ff.
               jd_ff <= j_ff; j_ff <= j_ff + 1'b1;
               state_ff <= S_RWAIT;
            end
            S_RWAIT: begin
               if (!tree_ff[jd] && rd_present && (!kv_ff[jd] || dsel)) begin
                  key_ff[jd] <= rd_weight; kv_ff[jd] <= 1'b1;
                  par_ff[jd] <= u_ff[VW-1:0];
               end
               if (j_ff == n) begin
                  if (added_ff == n) begin
                     j_ff <= (VW+1)'(1); state_ff <= S_EREAD;
                  end else begin
                     j_ff <= '0; pick_ff <= n; state_ff <= S_PICK;
                  end
               end else begin
                  state_ff <= S_RELAX;
               end
            end
            S_PICK: begin
               jd_ff <= j_ff; j_ff <= j_ff + 1'b1;
               state_ff <= S_PWAIT;
            end
            S_PWAIT: begin
               if (cand) begin
                  pick_ff <= jd_ff; pkey_ff <= kq_ff;
               end
               if (j_ff == n) begin
                  j_ff <= '0;
                  if (!cand && pick_ff == n) begin
                     rst_ff <= ST_NO_TREE; state_ff <= S_ONE;
                  end else begin
                     u_ff <= cand ? jd_ff : pick_ff;
                     tree_ff[cand ? jd : pick_ff[VW-1:0]] <= 1'b1;
                     added_ff <= added_ff + 1'b1;
                     state_ff <= S_RELAX;
                  end
               end else begin
                  state_ff <= S_PICK;
               end
            end
            S_EREAD: state_ff <= S_EMIT;
            S_EMIT: begin
               if (!rv_ff || !rsp_stall) begin
                  rv_ff <= 1'b1; rst_ff <= ST_TREE_EDGE;
                  rc_ff <= 7'(j_ff) + 7'd1;
                  rp_ff <= 7'(pq_ff) + 7'd1;
                  rl_ff <= (j_ff == n - 1'b1);
                  if (j_ff == n - 1'b1) begin
                     state_ff <= S_DONE;
                  end else begin
                     j_ff <= j_ff + 1'b1; state_ff <= S_EREAD;
                  end
               end
            end
            S_ONE: begin
               rv_ff <= 1'b1; state_ff <= S_DONE;
            end
            S_DONE: begin
               count_ff <= '0; failed_ff <= 1'b0; state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = rst_ff;
   assign rsp_child_vertex = rc_ff;
   assign rsp_parent_vertex = rp_ff;
   assign rsp_last = rl_ff;
endmodule

// ----- hdl/prim_minimum_spanning_tree.sv -----
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree
// Prim spanning tree over an adjacency matrix loaded edge by edge.
// ----------------------------------------------------------------------------
// channel   direction  handshake
// req_*     in         req_valid / req_stall
// rsp_*     out        rsp_valid / rsp_stall
// csr_*     in         csr_write, no wait
// An edge item makes two memory writes on one port.
// A solve alternates relax and pick passes, each scanning the vertices with
// registered reads, then emits one item per tree edge.
// Reset is synchronous; a sweep clears the matrix after reset and after
// every fifteenth solve, and requests stall meanwhile.
// A stalled result holds the sequencer; requests stall while busy.
`include "assert_macros.svh"
module prim_minimum_spanning_tree import pmst_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [6:0]  csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [7:0]  req_first_vertex,
   input  logic [7:0]  req_second_vertex,
   input  logic [32:0] req_edge_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [6:0]  rsp_child_vertex,
   output logic [6:0]  rsp_parent_vertex,
   output logic        rsp_last
);
   mem_req_type   mreq;
   logic          store_busy;
   logic          rd_present;
   logic [KW-1:0] rd_weight;

   pmst_store u_store (.clock, .reset, .req(mreq), .busy(store_busy), .rd_present,
      .rd_weight);

   pmst_seq u_seq (.clock, .reset, .csr_write, .csr_data, .req_valid, .req_stall,
      .req_opcode, .req_first_vertex, .req_second_vertex, .req_edge_length,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_child_vertex,
      .rsp_parent_vertex, .rsp_last, .mreq, .store_busy, .rd_present, .rd_weight);

   `ASSERT_IMPL(a_err_last, clock, reset, rsp_valid && rsp_status != ST_TREE_EDGE, rsp_last)
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_child_vertex))
   `ASSERT_IMPL(a_busy, clock, reset, rsp_valid, req_stall)
endmodule
